// ===== rtl/ieb_pkg.sv =====
package ieb_pkg;

  // Sizes of the problem the block is built for.
  localparam int NUM_VARIABLES    = 1024;
  localparam int NUM_EQUATIONS    = 1024;
  localparam int MAX_INSTRUCTIONS = 65536;

  localparam int TableDepth = 1024;

  // Effective bounds, each clamped to what the field widths can carry.
  localparam logic [10:0] IDX_LIMIT =
      11'((NUM_VARIABLES < TableDepth) ? NUM_VARIABLES : TableDepth);
  localparam logic [10:0] EQ_LIMIT =
      11'((NUM_EQUATIONS < 1024) ? NUM_EQUATIONS : 1024);
  localparam logic [11:0] VARNUM_LIMIT =
      12'((NUM_VARIABLES < 2048) ? NUM_VARIABLES : 2048);
  localparam logic [15:0] INSTR_LIMIT =
      16'((MAX_INSTRUCTIONS < 65535) ? MAX_INSTRUCTIONS : 65535);

  // Operand kinds.
  localparam logic [1:0] KIND_OTHER        = 2'd0;
  localparam logic [1:0] KIND_ALGEBRAIC    = 2'd1;
  localparam logic [1:0] KIND_DIFFERENTIAL = 2'd2;

  // Configuration register indexes.
  localparam logic REG_INIT_MODE = 1'b0;

  typedef struct packed {
    logic [1:0] operand_kind;
    logic [9:0] variable_index;
    logic       equation_end;
  } ieb_req_t;

  typedef struct packed {
    logic        edge_valid;
    logic [9:0]  edge_equation;
    logic [10:0] edge_variable;
    logic        new_variable;
    logic        boundary_valid;
    logic [15:0] next_residual_start;
    logic [10:0] algebraic_count;
    logic [10:0] differential_count;
    logic        error;
  } ieb_res_t;

  // One table entry: one-based graph variable number (zero means unseen)
  // and the equation that last took an edge to it.
  typedef struct packed {
    logic [11:0] seen_id;
    logic [9:0]  last_eq;
  } ieb_entry_t;

endpackage

// ===== rtl/ieb_stream_if.sv =====
interface ieb_req_if
  import ieb_pkg::*;
();
  logic     valid;
  logic     ready;
  ieb_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ieb_res_if
  import ieb_pkg::*;
();
  logic     valid;
  logic     ready;
  ieb_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/incidence_edge_builder.sv =====
// Channel   Direction  Content
// --------  ---------  -----------------------------------------------
// req_i     in         operand_kind, variable_index, equation_end
// res_o     out        edge, boundary, counts and error of one request
// APB       in/out     initializer_mode at byte address 0
//
// One request per cycle is sustained while res_o is not stalled. A result passes
// through the table stage register and the output register after its request is taken.
// The single read port of the variable table allows one request per cycle, and a
// read-after-write to the same entry by the next request is forwarded.
// After reset a clearing pass writes all 2048 table entries, one per cycle,
// and no request is taken until that pass is done.
// A stalled result holds in the output register while the next request still
// enters the table stage.
module incidence_edge_builder
  import ieb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ieb_req_if.sink          req_i,
  ieb_res_if.source        res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int MemDepth = 2 * TableDepth;
  localparam int AddrW    = $clog2(MemDepth);

  // Configuration
  logic init_mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_INIT_MODE)) begin
      init_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_INIT_MODE) ? {31'd0, init_mode_q} : 32'd0;

  // Table memory and its clearing pass
  ieb_entry_t mem_q [MemDepth];
  ieb_entry_t rdata_q;
  logic       clr_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  ieb_entry_t       mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  // Pipeline control
  logic     s1_v_q;
  ieb_req_t s1_q;
  logic     s1_fire;
  logic     req_fire;
  logic     res_v_q;
  ieb_res_t res_q;

  logic       fwd_hit_q;
  ieb_entry_t fwd_data_q;

  // Architectural counters
  logic [10:0] eq_cnt_q;
  logic [11:0] next_var_q;
  logic [15:0] instr_cnt_q;
  logic [10:0] alg_tot_q;
  logic [10:0] dif_tot_q;

  logic [10:0] eq_cnt_d;
  logic [11:0] next_var_d;
  logic [15:0] instr_cnt_d;
  logic [10:0] alg_tot_d;
  logic [10:0] dif_tot_d;

  logic [AddrW-1:0] s1_addr;
  logic             upd_we;
  ieb_entry_t       upd_wdata;
  ieb_res_t         res_d;

  assign s1_fire   = s1_v_q && (!res_v_q || res_o.ready);
  assign req_i.ready = !clr_q && (!s1_v_q || s1_fire);
  assign req_fire  = req_i.valid && req_i.ready;
  assign mem_raddr = {req_i.payload.operand_kind == KIND_DIFFERENTIAL,
                      req_i.payload.variable_index};
  assign s1_addr   = {s1_q.operand_kind == KIND_DIFFERENTIAL, s1_q.variable_index};

  assign mem_we    = clr_q || (s1_fire && upd_we);
  assign mem_waddr = clr_q ? clr_cnt_q : s1_addr;
  assign mem_wdata = clr_q ? '0 : upd_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(MemDepth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // The memory reads the old entry when the request ahead writes it in the
  // same cycle, so that write is kept and used in place of the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (req_fire) begin
      fwd_hit_q <= s1_fire && upd_we && (s1_addr == mem_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      fwd_data_q <= upd_wdata;
    end
  end

  // Table stage: decide, update the entry and the counters
  always_comb begin
    logic        is_var;
    logic        is_diff;
    logic [10:0] eq_index;
    ieb_entry_t  entry;
    logic        ok;
    logic        is_new;
    logic [16:0] instr_next;
    logic        instr_over;

    is_var   = (s1_q.operand_kind == KIND_ALGEBRAIC) ||
               (s1_q.operand_kind == KIND_DIFFERENTIAL);
    is_diff  = (s1_q.operand_kind == KIND_DIFFERENTIAL);
    eq_index = eq_cnt_q - 11'd1;
    entry    = fwd_hit_q ? fwd_data_q : rdata_q;
    is_new   = (entry.seen_id == 12'd0);

    eq_cnt_d    = eq_cnt_q;
    next_var_d  = next_var_q;
    alg_tot_d   = alg_tot_q;
    dif_tot_d   = dif_tot_q;
    upd_we      = 1'b0;
    upd_wdata   = entry;
    res_d       = '0;

    ok = is_var && !(is_diff && init_mode_q) &&
         ({1'b0, s1_q.variable_index} < IDX_LIMIT) && (eq_index < EQ_LIMIT);

    if (is_var && !ok) begin
      res_d.error = 1'b1;
    end else if (ok && is_new) begin
      if ((next_var_q - 12'd1) >= VARNUM_LIMIT) begin
        res_d.error = 1'b1;
      end else begin
        upd_we              = 1'b1;
        upd_wdata.seen_id   = next_var_q;
        upd_wdata.last_eq   = eq_index[9:0];
        res_d.edge_valid    = 1'b1;
        res_d.new_variable  = 1'b1;
        res_d.edge_equation = eq_index[9:0];
        res_d.edge_variable = 11'(next_var_q - 12'd1);
        next_var_d          = next_var_q + 12'd1;
        if (is_diff) begin
          dif_tot_d = dif_tot_q + 11'd1;
        end else begin
          alg_tot_d = alg_tot_q + 11'd1;
        end
      end
    end else if (ok && (entry.last_eq != eq_index[9:0])) begin
      upd_we              = 1'b1;
      upd_wdata.last_eq   = eq_index[9:0];
      res_d.edge_valid    = 1'b1;
      res_d.edge_equation = eq_index[9:0];
      res_d.edge_variable = 11'(entry.seen_id - 12'd1);
    end

    instr_next = {1'b0, instr_cnt_q} + 17'd1;
    instr_over = instr_next > {1'b0, INSTR_LIMIT};
    if (instr_over) begin
      instr_next = {1'b0, INSTR_LIMIT};
    end
    instr_cnt_d = instr_next[15:0];

    if (s1_q.equation_end) begin
      res_d.boundary_valid      = 1'b1;
      res_d.next_residual_start = instr_next[15:0];
      if (instr_over) begin
        res_d.error = 1'b1;
      end
      if (eq_cnt_q > EQ_LIMIT) begin
        res_d.error = 1'b1;
      end else begin
        eq_cnt_d = eq_cnt_q + 11'd1;
      end
    end

    res_d.algebraic_count    = alg_tot_d;
    res_d.differential_count = dif_tot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      res_v_q     <= 1'b0;
      eq_cnt_q    <= 11'd1;
      next_var_q  <= 12'd1;
      instr_cnt_q <= 16'd0;
      alg_tot_q   <= 11'd0;
      dif_tot_q   <= 11'd0;
    end else begin
      if (req_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        res_v_q     <= 1'b1;
        eq_cnt_q    <= eq_cnt_d;
        next_var_q  <= next_var_d;
        instr_cnt_q <= instr_cnt_d;
        alg_tot_q   <= alg_tot_d;
        dif_tot_q   <= dif_tot_d;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_q <= req_i.payload;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_v_q;
  assign res_o.payload = res_q;

  // Checks
  a_no_req_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_q |-> !req_i.ready)
    else $error("request taken during table clearing");

  a_fwd_follows_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(fwd_hit_q) |-> $past(mem_we))
    else $error("forwarding hit without a table write");

  a_var_numbering : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, alg_tot_q} + {1'b0, dif_tot_q}) == (next_var_q - 12'd1))
    else $error("variable totals disagree with the next variable number");

  a_eq_counter_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (eq_cnt_q != 11'd0) && (eq_cnt_q <= EQ_LIMIT + 11'd1))
    else $error("equation counter out of range");

  a_no_write_when_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (!clr_q && !s1_v_q) |-> !mem_we)
    else $error("table written with no request in the table stage");

endmodule

// ===== tb/sv/incidence_edge_checker.sv =====
module incidence_edge_checker
  import ieb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ieb_req_if          req_i,
  ieb_res_if          res_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  logic        init_mode;
  logic [11:0] alg_id   [TableDepth];
  logic [9:0]  alg_eq   [TableDepth];
  logic [11:0] diff_id  [TableDepth];
  logic [9:0]  diff_eq  [TableDepth];
  logic [10:0] eq_count;
  logic [11:0] next_var;
  logic [15:0] instr_count;
  logic [10:0] alg_total;
  logic [10:0] diff_total;

  ieb_res_t awaited_results [$];
  int       mismatches;

  function automatic void check_field(input string field, input logic [15:0] expected,
                                      input logic [15:0] actual);
    if (actual !== expected) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    end
  endfunction

  // Advances the table and counter state by one request and returns the result it causes.
  function automatic ieb_res_t predict_incidence(input ieb_req_t r);
    ieb_res_t    o;
    logic [10:0] eq_idx;
    logic [11:0] id;
    logic [9:0]  last_eq;
    logic [16:0] next_off;
    logic        is_diff;
    logic        is_var;
    logic        over;
    o       = '0;
    eq_idx  = eq_count - 11'd1;
    is_diff = (r.operand_kind == KIND_DIFFERENTIAL);
    is_var  = is_diff || (r.operand_kind == KIND_ALGEBRAIC);
    if (is_var) begin
      id      = is_diff ? diff_id[r.variable_index] : alg_id[r.variable_index];
      last_eq = is_diff ? diff_eq[r.variable_index] : alg_eq[r.variable_index];
      if (is_diff && init_mode) begin
        o.error = 1'b1;
      end else if ({1'b0, r.variable_index} >= IDX_LIMIT || eq_idx >= EQ_LIMIT) begin
        o.error = 1'b1;
      end else if (id == '0) begin
        if (next_var - 12'd1 >= VARNUM_LIMIT) begin
          o.error = 1'b1;
        end else begin
          if (is_diff) begin
            diff_id[r.variable_index] = next_var;
            diff_eq[r.variable_index] = eq_idx[9:0];
            diff_total = diff_total + 11'd1;
          end else begin
            alg_id[r.variable_index] = next_var;
            alg_eq[r.variable_index] = eq_idx[9:0];
            alg_total = alg_total + 11'd1;
          end
          o.edge_valid    = 1'b1;
          o.new_variable  = 1'b1;
          o.edge_equation = eq_idx[9:0];
          o.edge_variable = 11'(next_var - 12'd1);
          next_var = next_var + 12'd1;
        end
      end else if (last_eq != eq_idx[9:0]) begin
        if (is_diff) diff_eq[r.variable_index] = eq_idx[9:0];
        else alg_eq[r.variable_index] = eq_idx[9:0];
        o.edge_valid    = 1'b1;
        o.edge_equation = eq_idx[9:0];
        o.edge_variable = 11'(id - 12'd1);
      end
    end

    // The instruction offset saturates; a closing request past the bound is flagged.
    next_off = {1'b0, instr_count} + 17'd1;
    over     = next_off > {1'b0, INSTR_LIMIT};
    if (over) next_off = {1'b0, INSTR_LIMIT};
    if (r.equation_end) begin
      o.boundary_valid      = 1'b1;
      o.next_residual_start = next_off[15:0];
      if (over) o.error = 1'b1;
      if (eq_count > EQ_LIMIT) o.error = 1'b1;
      else eq_count = eq_count + 11'd1;
    end
    instr_count        = next_off[15:0];
    o.algebraic_count    = alg_total;
    o.differential_count = diff_total;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ieb_res_t expected;
    ieb_res_t actual;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        alg_id[i]  = '0;
        alg_eq[i]  = '0;
        diff_id[i] = '0;
        diff_eq[i] = '0;
      end
      init_mode   = 1'b0;
      eq_count    = 11'd1;
      next_var    = 12'd1;
      instr_count = '0;
      alg_total   = '0;
      diff_total  = '0;
      mismatches  = 0;
      awaited_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_INIT_MODE, 2'b00})
        init_mode = pwdata[0];
      if (req_i.valid && req_i.ready)
        awaited_results = {awaited_results, predict_incidence(req_i.payload)};
      if (res_i.valid && res_i.ready) begin
        actual = res_i.payload;
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, actual);
        end else begin
          expected = awaited_results.pop_front();
          check_field("edge_valid", expected.edge_valid, actual.edge_valid);
          check_field("edge_equation", expected.edge_equation, actual.edge_equation);
          check_field("edge_variable", expected.edge_variable, actual.edge_variable);
          check_field("new_variable", expected.new_variable, actual.new_variable);
          check_field("boundary_valid", expected.boundary_valid, actual.boundary_valid);
          check_field("next_residual_start", expected.next_residual_start,
                      actual.next_residual_start);
          check_field("algebraic_count", expected.algebraic_count, actual.algebraic_count);
          check_field("differential_count", expected.differential_count,
                      actual.differential_count);
          check_field("error", expected.error, actual.error);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_incidence_edge_builder.sv =====
module tb_incidence_edge_builder;
  import ieb_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  // Total number of requests in the run.
  localparam int unsigned InstructionTarget = 1450;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          results_pending;
  int unsigned requests_sent;
  int unsigned cycle_count = 0;
  int unsigned gap_odds = 8;
  bit          stall_enable = 1'b1;

  ieb_req_if req_if ();
  ieb_res_if res_if ();

  incidence_edge_builder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  incidence_edge_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side back-pressure: mostly short runs, sometimes long stretches without a stall.
  initial begin : result_pacing
    int unsigned run;
    res_if.ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) @(posedge clk_i);
      if (stall_enable) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [9:0] index,
                              input logic last);
    ieb_req_t request;
    request.operand_kind   = kind;
    request.variable_index = index;
    request.equation_end   = last;
    if (stall_enable && $urandom_range(1, gap_odds) == 1) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= request;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_INIT_MODE, 2'b00};
    pwdata  <= {$urandom} & 32'hFFFF_FFFE | {31'd0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [1:0] random_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return KIND_ALGEBRAIC;
    if (roll < 65) return KIND_DIFFERENTIAL;
    if (roll < 90) return KIND_OTHER;
    return KIND_UNUSED;
  endfunction

  // One residual equation; most operands come from a small window so variables recur.
  task automatic send_equation(input logic [9:0] hot_base);
    int unsigned length;
    logic [9:0]  index;
    length = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    for (int unsigned n = 1; n <= length; n++) begin
      index = ($urandom_range(0, 9) < 7) ? hot_base + 10'($urandom_range(0, 15))
                                         : 10'($urandom);
      send_request(random_kind(), index, n == length || $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin : stimulus
    logic [9:0] hot_base;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    requests_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(1'b0);
    send_request(KIND_ALGEBRAIC, 10'd0, 1'b0);
    send_request(KIND_ALGEBRAIC, 10'h3FF, 1'b0);
    send_request(KIND_DIFFERENTIAL, 10'd0, 1'b0);
    send_request(KIND_DIFFERENTIAL, 10'h3FF, 1'b0);
    send_request(KIND_ALGEBRAIC, 10'd0, 1'b0);
    send_request(KIND_UNUSED, 10'h3FF, 1'b0);
    send_request(KIND_OTHER, 10'h2AA, 1'b1);
    // Known variables in a fresh equation take an edge without a new number.
    send_request(KIND_ALGEBRAIC, 10'd0, 1'b0);
    send_request(KIND_DIFFERENTIAL, 10'h3FF, 1'b1);
    send_request(KIND_OTHER, 10'h155, 1'b1);
    set_mode(1'b1);
    send_request(KIND_DIFFERENTIAL, 10'd5, 1'b0);
    send_request(KIND_ALGEBRAIC, 10'd5, 1'b0);
    send_request(KIND_DIFFERENTIAL, 10'd0, 1'b1);
    send_request(KIND_UNUSED, 10'd0, 1'b1);
    set_mode(1'b0);
    send_request(KIND_DIFFERENTIAL, 10'd5, 1'b0);
    send_request(KIND_ALGEBRAIC, 10'h3FF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase % 2 == 0);
      gap_odds = (phase % 2 == 0) ? 4 : 30;
      hot_base = 10'($urandom);
      while (requests_sent < 17 + 40 * (phase + 1)) send_equation(hot_base);
    end

    // Many differential variables in one equation, so that the algebraic sweep
    // below runs out of graph variable numbers before the equations run out.
    set_mode(1'b0);
    gap_odds = 8;
    for (int i = 0; i < 128; i++)
      send_request(KIND_DIFFERENTIAL, 10'(i), i == 127);

    // Every algebraic entry in an equation of its own: the variable numbers run
    // out first, then the equation counter passes its end.
    for (int i = 0; i < 1024; i++)
      send_request(KIND_ALGEBRAIC, 10'(i), 1'b1);

    stall_enable = 1'b0;
    while (requests_sent < InstructionTarget)
      send_request(random_kind(), 10'($urandom),
                   requests_sent + 6 >= InstructionTarget || $urandom_range(0, 199) == 0);
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
